@@ hdl/flow_space_read_length_core_defines.svh @@
// ----------------------------------------------------------------------------
// flow space read length core assertion macros
// concurrent assertion wrappers, compiled out with NO_ASSERTIONS
// ----------------------------------------------------------------------------
`ifndef FLOW_SPACE_READ_LENGTH_CORE_DEFINES_SVH
`define FLOW_SPACE_READ_LENGTH_CORE_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define FSRL_ASSERT_ALWAYS(lbl, c, r, expr, msg) \
  lbl: assert property (@(posedge c) disable iff (!r) (expr)) else $error(msg);
`define FSRL_ASSERT_NEXT(lbl, c, r, ante, cons, msg) \
  lbl: assert property (@(posedge c) disable iff (!r) (ante) |=> (cons)) else $error(msg);
`else
`define FSRL_ASSERT_ALWAYS(lbl, c, r, expr, msg)
`define FSRL_ASSERT_NEXT(lbl, c, r, ante, cons, msg)
`endif
`endif

@@ hdl/fsrl_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsrl_pkg
// shared types and constants of the flow space read length core
// ----------------------------------------------------------------------------
package fsrl_pkg;

  localparam int MAX_BASES_DEF = 256;
  localparam int BASE_W        = 2;
  localparam int INV_W         = 16;
  localparam int CFG_DATA_W    = 16;
  localparam int READ_LEN_W    = 9;

  localparam logic [INV_W-1:0] INV_RESET  = 16'd10;
  localparam logic             BEST_RESET = 1'b1;

  typedef enum logic [1:0] {
    CMD_APPEND_REF  = 2'd0,
    CMD_APPEND_READ = 2'd1,
    CMD_EVALUATE    = 2'd2,
    CMD_CLEAR_REF   = 2'd3
  } cmd_t;

  typedef enum logic [0:0] {
    CFG_ERR_RATIO_INV = 1'b0,
    CFG_BEST_MODE     = 1'b1
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_MUL,
    ST_CMP,
    ST_DONE
  } state_t;

  typedef struct packed {
    cmd_t              command;
    logic [BASE_W-1:0] base;
  } in_item_t;

  typedef struct packed {
    logic [READ_LEN_W-1:0] read_length;
    logic                  overflow;
  } out_item_t;

  typedef struct packed {
    logic append_ref;
    logic append_read;
    logic clear_ref;
    logic start_eval;
    logic scan_step;
    logic flow_skip;
    logic flow_end;
    logic mul;
    logic cmp;
    logic load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic any_hit;
    logic zero_flow;
    logic more;
    logic stop;
    logic out_free;
  } dp_status_t;

endpackage

@@ hdl/fsrl_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsrl_ram
// generic single write port ram with registered read
// ----------------------------------------------------------------------------
module fsrl_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ hdl/fsrl_dp.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsrl_dp
// base stores, run counters, error accumulation and ratio test
// ----------------------------------------------------------------------------
`include "flow_space_read_length_core_defines.svh"

module fsrl_dp #(
  parameter int MAX_BASES = fsrl_pkg::MAX_BASES_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  fsrl_pkg::in_item_t                   in_data,
  input  logic                                 cfg_we,
  input  fsrl_pkg::cfg_idx_t                   cfg_index,
  input  logic [fsrl_pkg::CFG_DATA_W-1:0]      cfg_wdata,
  input  fsrl_pkg::dp_cmd_t                    cmd,
  output fsrl_pkg::dp_status_t                 st,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output fsrl_pkg::out_item_t                  out_data
);

  localparam int CNT_W  = $clog2(MAX_BASES + 1);
  localparam int ADDR_W = $clog2(MAX_BASES);
  localparam int ERR_W  = CNT_W + 1;
  localparam int PROD_W = ERR_W + fsrl_pkg::INV_W;
  localparam int EXT_W  = fsrl_pkg::READ_LEN_W + CNT_W;
  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_BASES);

  logic [CNT_W-1:0] ref_count_r, ref_count_nxt;
  logic [CNT_W-1:0] read_count_r, read_count_nxt;
  logic [CNT_W-1:0] test_len_r, test_len_nxt;
  logic [CNT_W-1:0] ri_r, ri_nxt;
  logic [CNT_W-1:0] ti_r, ti_nxt;
  logic [CNT_W-1:0] rc_r, rc_nxt;
  logic [CNT_W-1:0] tc_r, tc_nxt;
  logic [CNT_W-1:0] length_r, length_nxt;
  logic [CNT_W-1:0] result_r, result_nxt;
  logic [ERR_W-1:0] errors_r, errors_nxt;
  logic [PROD_W-1:0] prod_r, prod_nxt;
  logic [1:0] flow_r, flow_nxt;
  logic mism_r, mism_nxt;
  logic dropped_r, dropped_nxt;
  logic [fsrl_pkg::INV_W-1:0] inv_r, inv_nxt;
  logic best_r, best_nxt;
  logic out_valid_r, out_valid_nxt;
  fsrl_pkg::out_item_t out_data_r, out_data_nxt;

  logic [fsrl_pkg::BASE_W-1:0] ref_q, read_q;
  logic ref_we, read_we;
  logic ref_ok, read_ok, ref_hit, read_hit, pass;
  logic [CNT_W-1:0] diff;
  logic [EXT_W-1:0] len_ext;

  fsrl_ram #(.WIDTH(fsrl_pkg::BASE_W), .DEPTH(MAX_BASES)) u_ref_ram (
    .clk   (clk),
    .we    (ref_we),
    .waddr (ref_count_r[ADDR_W-1:0]),
    .wdata (in_data.base),
    .raddr (ri_nxt[ADDR_W-1:0]),
    .rdata (ref_q)
  );

  fsrl_ram #(.WIDTH(fsrl_pkg::BASE_W), .DEPTH(MAX_BASES)) u_read_ram (
    .clk   (clk),
    .we    (read_we),
    .waddr (read_count_r[ADDR_W-1:0]),
    .wdata (in_data.base),
    .raddr (ti_nxt[ADDR_W-1:0]),
    .rdata (read_q)
  );

  assign ref_we  = cmd.append_ref && (ref_count_r < MAX_CNT);
  assign read_we = cmd.append_read && (read_count_r < MAX_CNT);

  assign ref_ok   = ri_r < ref_count_r;
  assign read_ok  = ti_r < test_len_r;
  assign ref_hit  = ref_ok && (ref_q == flow_r);
  assign read_hit = read_ok && (read_q == flow_r);
  assign diff     = (rc_r > tc_r) ? (rc_r - tc_r) : (tc_r - rc_r);
  assign pass     = (length_r == '0) ? (inv_r <= fsrl_pkg::INV_W'(1))
                                     : (prod_r <= PROD_W'(length_r));
  assign len_ext  = {{fsrl_pkg::READ_LEN_W{1'b0}}, result_r};

  assign st.any_hit   = ref_hit || read_hit;
  assign st.zero_flow = (rc_r == '0) && (tc_r == '0);
  assign st.more      = ref_ok && read_ok;
  assign st.stop      = mism_r && !best_r && !pass;
  assign st.out_free  = !out_valid_r || out_ready;

  always_comb begin
    ref_count_nxt  = ref_count_r;
    read_count_nxt = read_count_r;
    test_len_nxt   = test_len_r;
    ri_nxt         = ri_r;
    ti_nxt         = ti_r;
    rc_nxt         = rc_r;
    tc_nxt         = tc_r;
    length_nxt     = length_r;
    result_nxt     = result_r;
    errors_nxt     = errors_r;
    prod_nxt       = prod_r;
    flow_nxt       = flow_r;
    mism_nxt       = mism_r;
    dropped_nxt    = dropped_r;
    inv_nxt        = inv_r;
    best_nxt       = best_r;
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;

    if (cfg_we) begin
      case (cfg_index)
        fsrl_pkg::CFG_ERR_RATIO_INV: inv_nxt  = cfg_wdata[fsrl_pkg::INV_W-1:0];
        fsrl_pkg::CFG_BEST_MODE:     best_nxt = cfg_wdata[0];
        default: ;
      endcase
    end

    if (cmd.append_ref) begin
      if (ref_we) begin
        ref_count_nxt = ref_count_r + 1'b1;
      end else begin
        dropped_nxt = 1'b1;
      end
    end
    if (cmd.append_read) begin
      if (read_we) begin
        read_count_nxt = read_count_r + 1'b1;
      end else begin
        dropped_nxt = 1'b1;
      end
    end
    if (cmd.clear_ref) begin
      ref_count_nxt = '0;
    end

    if (cmd.start_eval) begin
      test_len_nxt   = (read_count_r > ref_count_r) ? ref_count_r : read_count_r;
      read_count_nxt = '0;
      ri_nxt         = '0;
      ti_nxt         = '0;
      rc_nxt         = '0;
      tc_nxt         = '0;
      length_nxt     = '0;
      result_nxt     = '0;
      errors_nxt     = '0;
      flow_nxt       = '0;
      mism_nxt       = 1'b0;
    end

    if (cmd.scan_step) begin
      if (ref_hit) begin
        ri_nxt = ri_r + 1'b1;
        rc_nxt = rc_r + 1'b1;
      end
      if (read_hit) begin
        ti_nxt = ti_r + 1'b1;
        tc_nxt = tc_r + 1'b1;
      end
    end

    if (cmd.flow_skip) begin
      flow_nxt = flow_r + 1'b1;
    end

    if (cmd.flow_end) begin
      flow_nxt   = flow_r + 1'b1;
      length_nxt = length_r + tc_r;
      errors_nxt = errors_r + ERR_W'(diff);
      mism_nxt   = rc_r != tc_r;
    end

    if (cmd.mul) begin
      prod_nxt = PROD_W'(errors_r) * PROD_W'(inv_r);
    end

    if (cmd.cmp) begin
      if ((!mism_r || best_r) ? pass : !pass) begin
        result_nxt = length_r;
      end
      rc_nxt = '0;
      tc_nxt = '0;
    end

    if (cmd.load_out) begin
      out_valid_nxt            = 1'b1;
      out_data_nxt.read_length = len_ext[fsrl_pkg::READ_LEN_W-1:0];
      out_data_nxt.overflow    = dropped_r;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ref_count_r  <= '0;
      read_count_r <= '0;
      test_len_r   <= '0;
      ri_r         <= '0;
      ti_r         <= '0;
      rc_r         <= '0;
      tc_r         <= '0;
      flow_r       <= '0;
      dropped_r    <= 1'b0;
      inv_r        <= fsrl_pkg::INV_RESET;
      best_r       <= fsrl_pkg::BEST_RESET;
      out_valid_r  <= 1'b0;
    end else begin
      ref_count_r  <= ref_count_nxt;
      read_count_r <= read_count_nxt;
      test_len_r   <= test_len_nxt;
      ri_r         <= ri_nxt;
      ti_r         <= ti_nxt;
      rc_r         <= rc_nxt;
      tc_r         <= tc_nxt;
      flow_r       <= flow_nxt;
      dropped_r    <= dropped_nxt;
      inv_r        <= inv_nxt;
      best_r       <= best_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    length_r   <= length_nxt;
    result_r   <= result_nxt;
    errors_r   <= errors_nxt;
    prod_r     <= prod_nxt;
    mism_r     <= mism_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `FSRL_ASSERT_ALWAYS(a_counts_bounded, clk, rst_n,
    (ref_count_r <= MAX_CNT) && (read_count_r <= MAX_CNT), "store count past depth")
  `FSRL_ASSERT_ALWAYS(a_read_index_bounded, clk, rst_n,
    ti_r <= test_len_r, "read index past capped length")
  `FSRL_ASSERT_NEXT(a_load_out_valid, clk, rst_n,
    cmd.load_out, out_valid_r, "result load did not raise out_valid")

endmodule

@@ hdl/fsrl_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsrl_ctrl
// command decode and evaluate sequencer
// ----------------------------------------------------------------------------
`include "flow_space_read_length_core_defines.svh"

module fsrl_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  fsrl_pkg::cmd_t       in_cmd,
  input  fsrl_pkg::dp_status_t st,
  output fsrl_pkg::dp_cmd_t    cmd
);

  fsrl_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= fsrl_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      fsrl_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          case (in_cmd)
            fsrl_pkg::CMD_APPEND_REF:  cmd.append_ref  = 1'b1;
            fsrl_pkg::CMD_APPEND_READ: cmd.append_read = 1'b1;
            fsrl_pkg::CMD_EVALUATE: begin
              cmd.start_eval = 1'b1;
              state_nxt      = fsrl_pkg::ST_SCAN;
            end
            fsrl_pkg::CMD_CLEAR_REF:   cmd.clear_ref   = 1'b1;
            default: ;
          endcase
        end
      end
      fsrl_pkg::ST_SCAN: begin
        if (st.any_hit) begin
          cmd.scan_step = 1'b1;
        end else if (st.zero_flow) begin
          cmd.flow_skip = 1'b1;
          if (!st.more) begin
            state_nxt = fsrl_pkg::ST_DONE;
          end
        end else begin
          cmd.flow_end = 1'b1;
          state_nxt    = fsrl_pkg::ST_MUL;
        end
      end
      fsrl_pkg::ST_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = fsrl_pkg::ST_CMP;
      end
      fsrl_pkg::ST_CMP: begin
        cmd.cmp = 1'b1;
        if (st.stop || !st.more) begin
          state_nxt = fsrl_pkg::ST_DONE;
        end else begin
          state_nxt = fsrl_pkg::ST_SCAN;
        end
      end
      fsrl_pkg::ST_DONE: begin
        if (st.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = fsrl_pkg::ST_IDLE;
        end
      end
      default: state_nxt = fsrl_pkg::ST_IDLE;
    endcase
  end

  `FSRL_ASSERT_NEXT(a_mul_then_cmp, clk, rst_n,
    state_r == fsrl_pkg::ST_MUL, state_r == fsrl_pkg::ST_CMP, "multiply not followed by test")
  `FSRL_ASSERT_NEXT(a_done_to_idle, clk, rst_n,
    (state_r == fsrl_pkg::ST_DONE) && st.out_free, state_r == fsrl_pkg::ST_IDLE,
    "result not handed off")

endmodule

@@ hdl/flow_space_read_length_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flow_space_read_length_core
// quality-passing read length over flow space homopolymer runs
// ----------------------------------------------------------------------------
// channel  dir  handshake            payload
// in_      in   in_valid/in_ready    in_data  (command, base)
// out_     out  out_valid/out_ready  out_data (read_length, overflow)
// cfg_     in   cfg_we               cfg_index, cfg_wdata
//
// append and clear transactions are taken in the idle state without leaving it
// evaluate scans both stores in parallel, one base a cycle while in the scan
//   state, and runs a multiply and a test state after each nonempty flow
// reset is synchronous; the base stores are not cleared, counts are cleared
// a pending result in the output register blocks only the next evaluate
// ----------------------------------------------------------------------------
module flow_space_read_length_core #(
  parameter int MAX_BASES = fsrl_pkg::MAX_BASES_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  fsrl_pkg::in_item_t              in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output fsrl_pkg::out_item_t             out_data,
  input  logic                            cfg_we,
  input  fsrl_pkg::cfg_idx_t              cfg_index,
  input  logic [fsrl_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  fsrl_pkg::dp_cmd_t    cmd;
  fsrl_pkg::dp_status_t st;

  fsrl_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_cmd   (in_data.command),
    .st       (st),
    .cmd      (cmd)
  );

  fsrl_dp #(.MAX_BASES(MAX_BASES)) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .st        (st),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// random and directed stimulus for the flow space read length core; a
// scoreboard predicts each evaluate transaction from a copy of both base
// stores and checks every output transaction field by field
// ----------------------------------------------------------------------------
module testbench;
  import fsrl_pkg::*;

  localparam int MAX_BASES      = MAX_BASES_DEF;
  localparam int PHASE_ITEMS    = 40;
  localparam int NUM_PHASES     = 9;
  localparam int SETTLE_CYCLES  = 16;
  localparam int WATCHDOG_LIMIT = 20000;

  logic                  clk;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  logic                  in_ready;
  in_item_t              in_data   = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  out_item_t             out_data;
  logic                  cfg_we    = 1'b0;
  cfg_idx_t              cfg_index = CFG_ERR_RATIO_INV;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  flow_space_read_length_core u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // predictor state
  logic [BASE_W-1:0] ref_store [MAX_BASES];
  logic [BASE_W-1:0] read_store [MAX_BASES];
  int                ref_fill   = 0;
  int                read_fill  = 0;
  bit                lost_base  = 1'b0;
  logic [INV_W-1:0]  ratio_inv  = INV_RESET;
  bit                keep_best  = BEST_RESET;
  out_item_t         pending_lengths [$];

  // stimulus planning state
  in_item_t          stim_items [$];
  logic [BASE_W-1:0] plan_ref [$];
  int                plan_read_fill = 0;
  int                phase_items    = 0;
  int                send_idle_pct  = 0;
  int                recv_idle_pct  = 0;

  bit                in_taken     = 1'b0;
  int                fail_count   = 0;
  int                stall_cycles = 0;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic bit length_passes(input longint errs, input longint len);
    if (len == 0) return ratio_inv <= 1;
    return errs * longint'(ratio_inv) <= len;
  endfunction

  function automatic logic [READ_LEN_W-1:0] flow_read_length();
    int          ri, ti, rlen, tlen, flow, rc, tc;
    longint      errs, len, best_len;
    logic [1:0]  code;
    bit          stopped;
    rlen     = ref_fill;
    tlen     = (read_fill > ref_fill) ? ref_fill : read_fill;
    ri       = 0;
    ti       = 0;
    flow     = 0;
    errs     = 0;
    len      = 0;
    best_len = 0;
    stopped  = 1'b0;
    while (!stopped && ri < rlen && ti < tlen) begin
      code = flow[1:0];
      rc   = 0;
      tc   = 0;
      while (ri < rlen && ref_store[ri] == code) begin
        rc++;
        ri++;
      end
      while (ti < tlen && read_store[ti] == code) begin
        tc++;
        ti++;
      end
      flow++;
      if (rc == tc && rc != 0) begin
        len += tc;
        if (length_passes(errs, len)) best_len = len;
      end else if (rc != tc) begin
        len  += tc;
        errs += (rc > tc) ? (rc - tc) : (tc - rc);
        if (keep_best) begin
          if (length_passes(errs, len)) best_len = len;
        end else if (!length_passes(errs, len)) begin
          best_len = len;
          stopped  = 1'b1;
        end
      end
    end
    return best_len[READ_LEN_W-1:0];
  endfunction

  function automatic void absorb_transaction(input in_item_t it);
    out_item_t res;
    case (it.command)
      CMD_APPEND_REF: begin
        if (ref_fill < MAX_BASES) begin
          ref_store[ref_fill] = it.base;
          ref_fill++;
        end else begin
          lost_base = 1'b1;
        end
      end
      CMD_APPEND_READ: begin
        if (read_fill < MAX_BASES) begin
          read_store[read_fill] = it.base;
          read_fill++;
        end else begin
          lost_base = 1'b1;
        end
      end
      CMD_EVALUATE: begin
        res.read_length = flow_read_length();
        res.overflow    = lost_base;
        pending_lengths.push_back(res);
        read_fill = 0;
      end
      default: begin
        ref_fill = 0;
      end
    endcase
  endfunction

  // scoreboard: output transactions first, then the accepted input
  always @(posedge clk) begin
    out_item_t want;
    in_taken = rst_n && in_valid && in_ready;
    if (rst_n && out_valid && out_ready) begin
      if (pending_lengths.size() == 0) begin
        $display("%0t unexpected transaction: read_length %0d overflow %0b",
                 $time, out_data.read_length, out_data.overflow);
        fail_count++;
      end else begin
        want = pending_lengths.pop_front();
        if (out_data.read_length !== want.read_length) begin
          $display("%0t read_length mismatch: expected %0d, actual %0d",
                   $time, want.read_length, out_data.read_length);
          fail_count++;
        end
        if (out_data.overflow !== want.overflow) begin
          $display("%0t overflow mismatch: expected %0b, actual %0b",
                   $time, want.overflow, out_data.overflow);
          fail_count++;
        end
      end
    end
    if (in_taken) absorb_transaction(in_data);
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (stim_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_data  <= stim_items.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles == WATCHDOG_LIMIT) begin
      $display("%0t watchdog timeout, %0d transactions outstanding",
               $time, pending_lengths.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  function automatic void push_cmd(input cmd_t c, input logic [BASE_W-1:0] b);
    in_item_t it;
    it.command = c;
    it.base    = b;
    stim_items.push_back(it);
    phase_items++;
    case (c)
      CMD_APPEND_REF: begin
        if (plan_ref.size() < MAX_BASES) plan_ref.push_back(b);
      end
      CMD_APPEND_READ: begin
        if (plan_read_fill < MAX_BASES) plan_read_fill++;
      end
      CMD_EVALUATE: begin
        plan_read_fill = 0;
      end
      default: begin
        plan_ref.delete();
      end
    endcase
  endfunction

  function automatic void gen_reference(input int n);
    logic [BASE_W-1:0] b;
    int                run;
    push_cmd(CMD_CLEAR_REF, BASE_W'($urandom));
    while (plan_ref.size() < n && plan_ref.size() < MAX_BASES) begin
      b   = BASE_W'($urandom);
      run = $urandom_range(1, 4);
      repeat (run) begin
        if (plan_ref.size() < n) push_cmd(CMD_APPEND_REF, b);
      end
    end
  endfunction

  // read derived from the planned reference with homopolymer style errors
  function automatic void gen_read();
    logic [BASE_W-1:0] rd [$];
    int                i, cut, room, err_pct;
    case ($urandom_range(3))
      0:       err_pct = 0;
      1:       err_pct = 3;
      2:       err_pct = 10;
      default: err_pct = 25;
    endcase
    cut = plan_ref.size();
    if (cut > 0 && $urandom_range(99) < 30) cut = $urandom_range(0, cut);
    for (i = 0; i < cut; i++) begin
      if ($urandom_range(99) < err_pct) begin
        case ($urandom_range(2))
          0: ; // dropped base
          1: begin
            rd.push_back(plan_ref[i]);
            rd.push_back(plan_ref[i]);
          end
          default: rd.push_back(BASE_W'($urandom));
        endcase
      end else begin
        rd.push_back(plan_ref[i]);
      end
    end
    if ($urandom_range(99) < 10) begin
      repeat ($urandom_range(1, 6)) rd.push_back(BASE_W'($urandom));
    end
    room = MAX_BASES - plan_read_fill;
    for (i = 0; i < rd.size() && i < room; i++) push_cmd(CMD_APPEND_READ, rd[i]);
    push_cmd(CMD_EVALUATE, BASE_W'($urandom));
  endfunction

  function automatic void random_sequence();
    int   kind, n;
    cmd_t c;
    kind = $urandom_range(99);
    if (kind < 70) begin
      if (plan_ref.size() == 0 || $urandom_range(1) == 1) begin
        n = ($urandom_range(99) < 4) ? $urandom_range(100, MAX_BASES) : $urandom_range(1, 24);
        gen_reference(n);
      end
      repeat ($urandom_range(1, 3)) gen_read();
    end else if (kind < 85) begin
      n = $urandom_range(0, 12);
      repeat (n) begin
        if (plan_read_fill < MAX_BASES) push_cmd(CMD_APPEND_READ, BASE_W'($urandom));
      end
      push_cmd(CMD_EVALUATE, BASE_W'($urandom));
    end else begin
      repeat ($urandom_range(1, 6)) begin
        c = cmd_t'($urandom_range(3));
        if ((c == CMD_APPEND_REF && plan_ref.size() >= MAX_BASES) ||
            (c == CMD_APPEND_READ && plan_read_fill >= MAX_BASES)) c = CMD_EVALUATE;
        push_cmd(c, BASE_W'($urandom));
      end
    end
  endfunction

  task automatic wait_drained();
    while (stim_items.size() != 0 || in_valid || pending_lengths.size() != 0) begin
      @(posedge clk);
    end
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we    <= 1'b0;
    if (idx == CFG_ERR_RATIO_INV) ratio_inv = val;
    else keep_best = val[0];
  endtask

  initial begin
    int               p, i;
    logic [INV_W-1:0] inv_plan [NUM_PHASES];
    bit               best_plan [NUM_PHASES];
    inv_plan  = '{16'd10, 16'd1, 16'd65535, 16'd2, 16'd0, 16'd7, 16'd65535, 16'd1, 16'd10};
    best_plan = '{1'b1, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0};
    inv_plan[5] = INV_W'($urandom_range(3, 40));
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    for (p = 0; p < NUM_PHASES; p++) begin
      if (p != 0) begin
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        write_reg(CFG_ERR_RATIO_INV, inv_plan[p]);
        write_reg(CFG_BEST_MODE, {15'($urandom), best_plan[p]});
      end
      case (p / 3)
        0: begin
          send_idle_pct = 9;
          recv_idle_pct = 58;
        end
        1: begin
          send_idle_pct = 58;
          recv_idle_pct = 9;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      phase_items = 0;
      if (p == 0) begin
        // empty stores, full flow cycle, mismatch at zero length, capped read
        push_cmd(CMD_EVALUATE, 2'd3);
        for (i = 0; i < 4; i++) push_cmd(CMD_APPEND_REF, BASE_W'(i));
        push_cmd(CMD_EVALUATE, 2'd0);
        for (i = 0; i < 4; i++) push_cmd(CMD_APPEND_READ, BASE_W'(i));
        push_cmd(CMD_EVALUATE, 2'd1);
        push_cmd(CMD_APPEND_READ, 2'd1);
        push_cmd(CMD_EVALUATE, 2'd2);
        push_cmd(CMD_CLEAR_REF, 2'd0);
        push_cmd(CMD_APPEND_READ, 2'd3);
        push_cmd(CMD_APPEND_READ, 2'd3);
        push_cmd(CMD_EVALUATE, 2'd3);
        push_cmd(CMD_APPEND_REF, 2'd3);
        push_cmd(CMD_APPEND_REF, 2'd3);
        repeat (4) push_cmd(CMD_APPEND_READ, 2'd3);
        push_cmd(CMD_EVALUATE, 2'd0);
      end
      if (p == NUM_PHASES - 1) begin
        // both stores overrun, the sticky flag shows on every later result
        push_cmd(CMD_CLEAR_REF, 2'd2);
        repeat (MAX_BASES + 3) push_cmd(CMD_APPEND_REF, BASE_W'($urandom));
        for (i = 0; i < plan_ref.size(); i++) push_cmd(CMD_APPEND_READ, plan_ref[i]);
        repeat (3) push_cmd(CMD_APPEND_READ, BASE_W'($urandom));
        push_cmd(CMD_EVALUATE, 2'd1);
        repeat (4) random_sequence();
      end
      while (phase_items < PHASE_ITEMS) random_sequence();
    end
    wait_drained();
    repeat (50) @(posedge clk);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
